>>> sv/dvfs_pkg.sv
package dvfs_pkg;

	localparam int TableEntries = 256;
	localparam int TableAw      = $clog2(TableEntries);
	localparam int MaxLevels    = 4;
	localparam int MaxWaves     = 255;
	localparam int LevelRegs    = 4;
	localparam int LevelAw      = 2;

	localparam logic [15:0] Q16Half = 16'h8000;
	localparam logic [15:0] Q16Max  = 16'hFFFF;

	// configuration register indexes
	localparam logic [2:0] RegLevel0   = 3'd0;
	localparam logic [2:0] RegLevel3   = 3'd3;
	localparam logic [2:0] RegLevelsIn = 3'd4;
	localparam logic [2:0] RegNominal  = 3'd5;

	localparam logic KindSample = 1'b0;
	localparam logic KindDecide = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [47:0] program_counter;
		logic [31:0] delta_cycles;
		logic [31:0] delta_stalls;
		logic [5:0]  domain_num;
	} in_item_t;

	typedef struct packed {
		logic [5:0]  out_domain;
		logic [1:0]  chosen_level;
		logic [15:0] avg_sensitivity;
	} out_item_t;

	typedef struct packed {
		logic [2:0]  index;
		logic [23:0] data;
	} cfg_item_t;

	// controller -> datapath commands
	typedef struct packed {
		logic load;       // capture input item
		logic div_start;  // start serial divider
		logic div_step;   // one quotient bit
		logic blend;      // compute blended value, write table, accumulate
		logic avg_start;  // start average division
		logic lvl_load;   // load level i operands
		logic mul_a;      // multiply stage a
		logic mul_b;      // cross products, low halves
		logic mul_c;      // cross products, high halves and sum
		logic cmp;        // compare and update best
		logic clr_sum;    // clear sum and count
		logic clr_step;   // clearing pass write
	} dp_cmd_t;

	typedef struct packed {
		logic        is_decide;
		logic        count_zero;
		logic        clr_done;
	} dp_sts_t;

endpackage

>>> sv/dvfs_ram.sv
module dvfs_ram #(
	parameter int Width = 16,
	parameter int Depth = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> sv/dvfs_datapath.sv
module dvfs_datapath import dvfs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  dp_cmd_t    cmd,
	output dp_sts_t    sts,
	input  in_item_t   in_item,
	input  logic [23:0] level_q [LevelRegs],
	input  logic [LevelAw-1:0] lvl_idx,
	input  logic [11:0] nominal_q,
	output out_item_t  result
);
	in_item_t item_q;
	logic [31:0] rem_q;
	logic [31:0] dvs_q;
	logic [16:0] quo_q;
	logic [47:0] num_q;
	logic        nbit;
	logic [33:0] trial;
	logic [23:0] sum_q;
	logic [7:0]  count_q;
	logic [TableAw-1:0] clr_q;
	logic [15:0] rdata;
	logic [15:0] avg_q;
	logic [15:0] q_sat;

	// serial restoring divider shared by the sensitivity and the average
	assign nbit  = num_q[47];
	assign trial = {1'b0, rem_q, nbit} - {2'b00, dvs_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_item;
		end
		if (cmd.div_start) begin
			// numerator (cycles-stalls)<<16, processed MSB first
			rem_q <= '0;
			dvs_q <= item_q.delta_cycles;
			quo_q <= '0;
		end else if (cmd.avg_start) begin
			rem_q <= '0;
			dvs_q <= {24'd0, count_q};
			quo_q <= '0;
		end else if (cmd.div_step) begin
			if (trial[33]) begin
				rem_q <= {rem_q[30:0], nbit};
				quo_q <= {quo_q[15:0], 1'b0};
			end else begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[15:0], 1'b1};
			end
		end
	end

	// numerator bit feed: shift register of the dividend
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			num_q <= {item_q.delta_cycles - item_q.delta_stalls, 16'd0};
		end else if (cmd.avg_start) begin
			num_q <= {sum_q, 24'd0};
		end else if (cmd.div_step) begin
			num_q <= {num_q[46:0], 1'b0};
		end
	end

	// quotient of one exactly saturates
	logic        s_zero;
	logic [15:0] s_val;
	assign q_sat  = quo_q[16] ? Q16Max : quo_q[15:0];
	assign s_zero = (item_q.delta_cycles == 32'd0) ||
		(item_q.delta_stalls >= item_q.delta_cycles);
	assign s_val  = s_zero ? 16'd0 : q_sat;

	logic [18:0] bl_num;
	logic [37:0] bl_prod;
	logic [15:0] blended;
	assign bl_num  = 19'(3 * 32'(s_val)) + 19'(2 * 32'(rdata)) + 19'd2;
	// x/5 as x*ceil(2^22/5) >> 22, exact for x below 2^22
	assign bl_prod = 38'(bl_num) * 38'd838861;
	assign blended = bl_prod[37:22];

	logic        we;
	logic [TableAw-1:0] waddr;
	logic [15:0] wdata;
	assign we    = cmd.blend || cmd.clr_step;
	assign waddr = cmd.clr_step ? clr_q : item_q.program_counter[TableAw-1:0];
	assign wdata = cmd.clr_step ? Q16Half : blended;

	dvfs_ram #(.Width(16), .Depth(TableEntries)) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(item_q.program_counter[TableAw-1:0]),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
			clr_q   <= '0;
		end else begin
			if (cmd.clr_step) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.clr_sum) begin
				sum_q   <= '0;
				count_q <= '0;
			end else if (cmd.blend && count_q < 8'(MaxWaves)) begin
				sum_q   <= sum_q + {8'd0, blended};
				count_q <= count_q + 1'b1;
			end
		end
	end

	// level search: cost = v*v*f, perf = nom<<16 + 5*s*f
	logic [11:0] f_q;
	logic [23:0] vv_s1;
	logic [35:0] cost_s2;
	logic [31:0] perf_s1;
	logic [63:0] pp_s2;
	logic [35:0] bcost_q;
	logic [63:0] bpp_q;
	logic        binf_q;
	logic        binf_q_valid;
	logic [1:0]  best_q;
	logic [11:0] lf, lv;

	assign lf = level_q[lvl_idx][11:0];
	assign lv = level_q[lvl_idx][23:12];

	// quotient stays put during the search, so the average is read from it
	always_ff @(posedge clk) begin
		if (cmd.lvl_load) begin
			f_q     <= lf;
			vv_s1   <= 24'(lv) * 24'(lv);
			perf_s1 <= {4'd0, nominal_q, 16'd0} + 32'(q_sat) * 32'(lf) * 32'd5;
		end
		if (cmd.mul_a) begin
			cost_s2 <= 36'(vv_s1) * 36'(f_q);
			pp_s2   <= 64'(perf_s1) * 64'(perf_s1);
		end
	end

	// cross products cost_i*pp_b vs cost_b*pp_i, split into low halves (mul_b) and high halves (mul_c)
	logic [67:0] lhs_lo_s3, rhs_lo_s3;
	logic [99:0] lhs_s4, rhs_s4;
	logic        take;
	always_ff @(posedge clk) begin
		if (cmd.mul_b) begin
			lhs_lo_s3 <= 68'(cost_s2) * 68'(bpp_q[31:0]);
			rhs_lo_s3 <= 68'(bcost_q) * 68'(pp_s2[31:0]);
		end
		if (cmd.mul_c) begin
			lhs_s4 <= {32'd0, lhs_lo_s3} + {68'(cost_s2) * 68'(bpp_q[63:32]), 32'd0};
			rhs_s4 <= {32'd0, rhs_lo_s3} + {68'(bcost_q) * 68'(pp_s2[63:32]), 32'd0};
		end
	end
	always_comb begin
		if (lvl_idx == '0 && !binf_q_valid) begin
			take = 1'b1;
		end else if (pp_s2 == '0) begin
			take = 1'b0;
		end else if (binf_q) begin
			take = 1'b1;
		end else begin
			take = lhs_s4 < rhs_s4;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			binf_q_valid <= 1'b0;
			binf_q       <= 1'b1;
			best_q       <= '0;
		end else begin
			if (cmd.avg_start) begin
				binf_q_valid <= 1'b0;
			end else if (cmd.cmp) begin
				binf_q_valid <= 1'b1;
				if (take) begin
					best_q <= 2'(lvl_idx);
					binf_q <= (pp_s2 == '0);
				end
			end
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.cmp && take) begin
			bcost_q <= cost_s2;
			bpp_q   <= pp_s2;
		end
		if (cmd.lvl_load && lvl_idx == '0) begin
			avg_q <= q_sat;
		end
	end

	assign result.out_domain      = item_q.domain_num;
	assign result.chosen_level    = best_q;
	assign result.avg_sensitivity = avg_q;

	assign sts.is_decide  = item_q.kind == KindDecide;
	assign sts.count_zero = count_q == 8'd0;
	assign sts.clr_done   = clr_q == TableAw'(TableEntries - 1);
endmodule

>>> sv/dvfs_ctrl.sv
module dvfs_ctrl import dvfs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_fire,
	input  logic       out_fire,
	input  logic [2:0] levels_q,
	input  dp_sts_t    sts,
	output dp_cmd_t    cmd,
	output logic       busy,
	output logic       out_valid_q,
	output logic [LevelAw-1:0] lvl_q
);
	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_SDIV, ST_READ, ST_BLEND,
		ST_ADIV, ST_LOAD, ST_MULA, ST_MULB, ST_MULC, ST_CMP, ST_OUT
	} state_t;

	state_t state_q;
	logic [5:0] cnt_q;
	logic [2:0] nlev;

	always_comb begin
		if (levels_q == 3'd0) begin
			nlev = 3'd1;
		end else if (levels_q > 3'(MaxLevels)) begin
			nlev = 3'(MaxLevels);
		end else begin
			nlev = levels_q;
		end
	end

	always_comb begin
		cmd = '0;
		cmd.load      = in_fire;
		cmd.clr_step  = state_q == ST_CLEAR;
		cmd.div_start = state_q == ST_DISPATCH && !sts.is_decide;
		cmd.avg_start = state_q == ST_DISPATCH && sts.is_decide && !sts.count_zero;
		cmd.clr_sum   = (state_q == ST_DISPATCH && sts.is_decide && sts.count_zero) ||
			(state_q == ST_LOAD && lvl_q == '0);
		cmd.div_step  = state_q == ST_SDIV || state_q == ST_ADIV;
		cmd.blend     = state_q == ST_BLEND;
		cmd.lvl_load  = state_q == ST_LOAD;
		cmd.mul_a     = state_q == ST_MULA;
		cmd.mul_b     = state_q == ST_MULB;
		cmd.mul_c     = state_q == ST_MULC;
		cmd.cmp       = state_q == ST_CMP;
	end

	assign busy = state_q != ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cnt_q       <= '0;
			lvl_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: if (sts.clr_done) state_q <= ST_IDLE;
				ST_IDLE: if (in_fire) state_q <= ST_DISPATCH;
				ST_DISPATCH: begin
					cnt_q <= '0;
					lvl_q <= '0;
					if (!sts.is_decide) begin
						state_q <= ST_SDIV;
					end else if (sts.count_zero) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_ADIV;
					end
				end
				ST_SDIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 6'd47) state_q <= ST_READ;
				end
				ST_READ: state_q <= ST_BLEND;
				ST_BLEND: state_q <= ST_IDLE;
				ST_ADIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 6'd23) state_q <= ST_LOAD;
				end
				ST_LOAD: state_q <= ST_MULA;
				ST_MULA: state_q <= ST_MULB;
				ST_MULB: state_q <= ST_MULC;
				ST_MULC: state_q <= ST_CMP;
				ST_CMP: begin
					if (3'(lvl_q) + 3'd1 >= nlev) begin
						state_q     <= ST_OUT;
						out_valid_q <= 1'b1;
					end else begin
						lvl_q   <= lvl_q + 1'b1;
						state_q <= ST_LOAD;
					end
				end
				ST_OUT: if (out_fire) begin
					out_valid_q <= 1'b0;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_out_only_in_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> state_q == ST_OUT) else $error("valid outside output state");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> state_q == ST_IDLE) else $error("accept while busy");
	a_lvl_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CMP |-> 3'(lvl_q) < nlev) else $error("level index out of range");
endmodule

>>> sv/dvfs_sensitivity_level_picker_unit.sv
// Sample items: one input transfer to the earliest next one runs through
//   the 48-step serial divide, table read and blend/write. Decide items: result
//   offered after the 24-step average divide and a load, MULA, MULB, MULC and
//   compare pass per searched level, held until its transfer; no waves: no result.
// One item in flight at a time; the shared serial divider sets the rate.
// Reset (arst_n low) clears control, sum and count, then a clearing pass
//   writes 0.5 to every table entry before the first input transfer.
module dvfs_sensitivity_level_picker_unit import dvfs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  cfg_item_t cfg_data
);
	logic [23:0] level_q [LevelRegs];
	logic [2:0]  levels_q;
	logic [11:0] nominal_q;
	logic        busy;
	logic        in_fire, out_fire;
	logic [LevelAw-1:0] lvl;
	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg_ready = 1'b1;
	assign in_ready  = !busy;
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid && out_ready;

	// config register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q[0] <= 24'd3277300;
			level_q[1] <= 24'd3687400;
			level_q[2] <= 24'd4097500;
			level_q[3] <= 24'd4507600;
			levels_q   <= 3'd4;
			nominal_q  <= 12'd2000;
		end else if (cfg_valid) begin
			if (cfg_data.index <= RegLevel3 && cfg_data.index >= RegLevel0) begin
				level_q[cfg_data.index[1:0]] <= cfg_data.data;
			end else if (cfg_data.index == RegLevelsIn) begin
				levels_q <= cfg_data.data[2:0];
			end else if (cfg_data.index == RegNominal) begin
				nominal_q <= cfg_data.data[11:0];
			end
		end
	end

	dvfs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_fire(out_fire),
		.levels_q(levels_q), .sts(sts), .cmd(cmd), .busy(busy),
		.out_valid_q(out_valid), .lvl_q(lvl)
	);

	dvfs_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .in_item(in_data),
		.level_q(level_q), .lvl_idx(lvl), .nominal_q(nominal_q), .result(out_data)
	);
endmodule

>>> tb/sv/tb_dvfs_sensitivity_level_picker_unit.sv
module tb_dvfs_sensitivity_level_picker_unit;
	import dvfs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// Expected decisions and a golden copy of the picker's state.
	class decision_board;
		logic [23:0] lvl_set [LevelRegs];
		logic [2:0]  lvl_used;
		logic [11:0] nom_mhz;
		logic [15:0] sens [TableEntries];
		logic [23:0] sum;
		logic [7:0]  waves;
		out_item_t   pending [$];
		int          errors;

		function new();
			lvl_set[0] = 24'd3277300;
			lvl_set[1] = 24'd3687400;
			lvl_set[2] = 24'd4097500;
			lvl_set[3] = 24'd4507600;
			lvl_used = 3'd4;
			nom_mhz = 12'd2000;
			foreach (sens[i]) sens[i] = Q16Half;
			sum = '0;
			waves = '0;
			errors = 0;
		endfunction

		function void write_reg(cfg_item_t c);
			if (c.index <= RegLevel3) lvl_set[c.index[1:0]] = c.data;
			else if (c.index == RegLevelsIn) lvl_used = c.data[2:0];
			else if (c.index == RegNominal) nom_mhz = c.data[11:0];
		endfunction

		function logic [15:0] sensitivity(logic [31:0] cyc, logic [31:0] stl);
			logic [63:0] q;
			if (cyc == 0 || stl >= cyc) return 16'd0;
			q = ({32'd0, cyc - stl} << 16) / cyc;
			return (q > Q16Max) ? Q16Max : q[15:0];
		endfunction

		function logic [1:0] best_level(logic [15:0] s);
			int n;
			logic [1:0] best;
			logic [63:0] bcost, bperf, cost, perf, f, v;
			logic [127:0] lhs, rhs;
			bit binf, inf, take;
			n = (lvl_used == 0) ? 1 : int'(lvl_used);
			if (n > MaxLevels) n = MaxLevels;
			if (n > LevelRegs) n = LevelRegs;
			best = '0; bcost = '0; bperf = '0; binf = 1;
			for (int i = 0; i < n; i++) begin
				f = 64'(lvl_set[i][11:0]);
				v = 64'(lvl_set[i][23:12]);
				cost = v * v * f;
				perf = ({52'd0, nom_mhz} << 16) + 64'd5 * 64'(s) * f;
				inf = (perf == 0);
				if (i == 0) take = 1;
				else if (inf) take = 0;
				else if (binf) take = 1;
				else begin
					lhs = 128'(cost) * 128'(bperf * bperf);
					rhs = 128'(bcost) * 128'(perf * perf);
					take = lhs < rhs;
				end
				if (take) begin
					best = i[1:0]; bcost = cost; bperf = perf; binf = inf;
				end
			end
			return best;
		endfunction

		function void note_input(in_item_t it);
			logic [7:0]  idx;
			logic [31:0] blend, avg;
			out_item_t   r;
			if (it.kind == KindSample) begin
				idx = it.program_counter[7:0];
				blend = (32'd3 * sensitivity(it.delta_cycles, it.delta_stalls)
					+ 32'd2 * sens[idx] + 32'd2) / 32'd5;
				if (blend > Q16Max) blend = Q16Max;
				sens[idx] = blend[15:0];
				if (waves < MaxWaves) begin
					sum = sum + blend[23:0];
					waves++;
				end
			end else begin
				if (waves != 0) begin
					avg = sum / waves;
					if (avg > Q16Max) avg = Q16Max;
					r.out_domain = it.domain_num;
					r.chosen_level = best_level(avg[15:0]);
					r.avg_sensitivity = avg[15:0];
					pending.push_back(r);
				end
				sum = '0;
				waves = '0;
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected decision %p", got);
				return;
			end
			e = pending.pop_front();
			if (got !== e) begin
				errors++;
				if (errors <= 10) $display("decision mismatch: exp %p got %p", e, got);
			end
		endfunction
	endclass

	logic      clk, arst_n;
	logic      in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
	in_item_t  in_data;
	out_item_t out_data;
	cfg_item_t cfg_data;

	decision_board board;
	int  idle_cycles = 0;
	bit  hold_off;
	bit  all_sent;

	dvfs_sensitivity_level_picker_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// score transfers at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) board.note_input(in_data);
			if (out_valid && out_ready) board.check_result(out_data);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// receiver: random stalls, plus a long hold-off when asked
	initial begin
		int g;
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_ready <= 0;
				// long stall counted here so the block backs up
				repeat (400) @(negedge clk);
				hold_off = 0;
			end else begin
				g = all_sent ? 0 : gap_len();
				if (g > 0) begin
					out_ready <= 0;
					repeat (g - 1) @(negedge clk);
				end else
					out_ready <= 1;
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (idle_cycles > 20000) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	task automatic send(in_item_t it);
		int g;
		g = gap_len();
		// valid goes low between items
		repeat (g + 1) @(negedge clk);
		in_valid <= 1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		in_valid <= 0;
	endtask

	task automatic drain();
		while (board.pending.size() != 0) @(negedge clk);
		// no-result items may still be in flight
		repeat (80) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [23:0] d);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_data <= '{index: idx, data: d};
		do @(posedge clk); while (!cfg_ready);
		board.write_reg(cfg_data);
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	function automatic in_item_t sample(logic [31:0] cyc, logic [31:0] stl);
		in_item_t it;
		it.kind = KindSample;
		it.program_counter = 48'({$urandom, $urandom});
		if ($urandom_range(0, 3) != 0) it.program_counter[7:0] = 8'($urandom_range(0, 15));
		it.delta_cycles = cyc;
		it.delta_stalls = stl;
		it.domain_num = 6'($urandom);
		return it;
	endfunction

	function automatic in_item_t decide();
		in_item_t it;
		it = sample($urandom, $urandom);
		it.kind = KindDecide;
		return it;
	endfunction

	function automatic in_item_t rand_sample();
		logic [31:0] c, s;
		case ($urandom_range(0, 5))
			0: begin c = $urandom; s = $urandom; end
			1: begin c = $urandom_range(0, 2000); s = $urandom_range(0, c); end
			2: begin c = $urandom; s = c - $urandom_range(0, 1000); end
			3: begin c = $urandom; s = $urandom_range(0, 50); end
			default: begin c = $urandom_range(1, 100000); s = $urandom_range(0, c); end
		endcase
		return sample(c, s);
	endfunction

	// one random configuration, extremes included
	task automatic random_config();
		logic [23:0] d;
		for (int i = 0; i <= RegLevel3; i++) begin
			case ($urandom_range(0, 5))
				0: d = 24'hFFFFFF;
				1: d = 24'd0;
				2: d = {12'($urandom_range(0, 4095)), 12'd0};
				default: d = {12'($urandom_range(600, 1200)), 12'($urandom_range(200, 2500))};
			endcase
			write_reg(i[2:0], d);
		end
		write_reg(RegLevelsIn, 24'($urandom_range(0, 7)));
		case ($urandom_range(0, 3))
			0: write_reg(RegNominal, 24'd0);
			1: write_reg(RegNominal, 24'hFFFFFF);
			default: write_reg(RegNominal, 24'($urandom_range(1, 4095)));
		endcase
	endtask

	initial begin
		int n;
		board = new();
		all_sent = 0;
		hold_off = 0;
		in_valid = 0;
		cfg_valid = 0;
		in_data = '0;
		cfg_data = '0;
		arst_n = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: special cases of the sensitivity and decision paths
		send(decide());                          // no waves yet
		send(sample(0, 5));                      // zero cycles
		send(sample(100, 100));                  // stalls equal cycles
		send(sample(100, 300));                  // stalls above cycles
		send(sample(32'hFFFFFFFF, 0));           // S saturates
		send(sample(32'hFFFFFFFF, 32'hFFFFFFFE));
		begin
			in_item_t it;
			it = sample(1, 0);
			it.program_counter = '1;
			send(it);
			it.program_counter = '0;
			send(it);
		end
		send(decide());
		send(decide());                          // count just cleared
		drain();
		write_reg(RegLevelsIn, 24'd0);
		write_reg(RegNominal, 24'd0);
		send(sample(10, 3));
		send(decide());
		drain();
		write_reg(RegLevel0, 24'hFFFFFF);
		write_reg(RegLevel3, 24'd0);
		write_reg(RegLevelsIn, 24'd7);
		write_reg(RegNominal, 24'hFFFFFF);
		send(sample(10, 3));
		send(decide());
		// count full: 260 samples before the next decide
		for (int i = 0; i < 260; i++) send(sample(32'hFFFFFFFF, 0));
		send(decide());
		drain();

		// random phases
		n = 0;
		for (int ph = 0; ph < 8; ph++) begin
			random_config();
			if (ph == 3) hold_off = 1;
			for (int k = 0; k < 33; k++) begin
				if ($urandom_range(0, 4) == 0) send(decide());
				else send(rand_sample());
				n++;
				// sender pause until everything is back
				if (ph == 5 && k == 16)
					while (board.pending.size() != 0) @(negedge clk);
			end
			send(decide());
			drain();
		end
		all_sent = 1;
		drain();
		if (board.errors == 0 && board.pending.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
